>>> src/pfrc_pkg.sv
// ----------------------------------------------------------------------------
// pfrc_pkg
// Shared types and constants of the pump fill/rest cycle controller.
// ----------------------------------------------------------------------------
package pfrc_pkg;

    localparam int unsigned DEPTH_W    = 16;
    localparam int unsigned BAND_W     = 15;
    localparam int unsigned SCALE_W    = 11;
    localparam int unsigned RESTSEL_W  = 8;
    localparam int unsigned MODE_W     = 2;
    localparam int unsigned CHAN_W     = 4;
    localparam int unsigned CMD_W      = 2;
    localparam int unsigned SEQ_W      = 32;
    localparam int unsigned PHASE_W    = 17;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam logic [PHASE_W-1:0]   RUN_SECONDS = PHASE_W'(1800);
    localparam logic [8:0]           REST_UNIT   = 9'd300;

    localparam logic [CFG_IDX_W-1:0] CFG_RADIO_MODE     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_DEPTH   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FILL_DEADBAND  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SCALE     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_REST_SELECTION = 3'd4;

    localparam logic [CMD_W-1:0] VALVE_CLOSED = 2'd0;
    localparam logic [CMD_W-1:0] VALVE_FILL   = 2'd1;
    localparam logic [CMD_W-1:0] VALVE_REST   = 2'd2;

    typedef struct packed {
        logic                      sensor_ok;
        logic                      hours_allowed;
        logic signed [DEPTH_W-1:0] average_depth;
        logic [CHAN_W-1:0]         radio_channel;
    } t_tick;

    typedef struct packed {
        logic capture;
        logic div_start;
        logic eval;
    } t_cmd;

    typedef struct packed {
        logic ignore;
        logic div_done;
        logic out_free;
    } t_status;

endpackage

>>> src/pfrc_tick_if.sv
// ----------------------------------------------------------------------------
// pfrc_tick_if
// Input channel: one sensor tick per transaction.
// ----------------------------------------------------------------------------
interface pfrc_tick_if;
    logic              valid;
    logic              ready;
    logic              sensor_ok;
    logic              hours_allowed;
    logic signed [15:0] average_depth;
    logic [3:0]        radio_channel;

    modport source (output valid, output sensor_ok, output hours_allowed,
                    output average_depth, output radio_channel, input ready);
    modport sink   (input valid, input sensor_ok, input hours_allowed,
                    input average_depth, input radio_channel, output ready);
endinterface

>>> src/pfrc_frame_if.sv
// ----------------------------------------------------------------------------
// pfrc_frame_if
// Output channel: one control frame per transaction.
// ----------------------------------------------------------------------------
interface pfrc_frame_if;
    logic        valid;
    logic        ready;
    logic [1:0]  valve_command;
    logic [31:0] frame_count;
    logic [3:0]  channel_out;
    logic        valve_second;

    modport source (output valid, output valve_command, output frame_count,
                    output channel_out, output valve_second, input ready);
    modport sink   (input valid, input valve_command, input frame_count,
                    input channel_out, input valve_second, output ready);
endinterface

>>> src/pfrc_div.sv
// ----------------------------------------------------------------------------
// pfrc_div
// Dual restoring divider: run and rest limits by time scale, one bit a cycle.
// ----------------------------------------------------------------------------
module pfrc_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pfrc_pkg::PHASE_W-1:0]   i_run_dividend,
    input  logic [pfrc_pkg::PHASE_W-1:0]   i_rest_dividend,
    input  logic [pfrc_pkg::SCALE_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [pfrc_pkg::PHASE_W-1:0]   o_run_q,
    output logic [pfrc_pkg::PHASE_W-1:0]   o_rest_q
);
    import pfrc_pkg::*;

    localparam int unsigned REM_W = SCALE_W + 1;
    localparam int unsigned CNT_W = $clog2(PHASE_W);

    logic [REM_W-1:0]   r_run_rem, r_rest_rem, n_run_rem, n_rest_rem;
    logic [PHASE_W-1:0] r_run_q, r_rest_q, n_run_q, n_rest_q;
    logic [SCALE_W-1:0] r_divisor;
    logic [CNT_W-1:0]   r_count;
    logic               r_busy;
    logic               r_done;

    function automatic logic [REM_W+PHASE_W-1:0] div_step(
        input logic [REM_W-1:0]   rem,
        input logic [PHASE_W-1:0] quo,
        input logic [SCALE_W-1:0] dsr
    );
        logic [REM_W-1:0] sh;
        logic             fits;
        sh   = {rem[REM_W-2:0], quo[PHASE_W-1]};
        fits = (sh >= {1'b0, dsr});
        if (fits) begin
            sh = sh - {1'b0, dsr};
        end
        return {sh, quo[PHASE_W-2:0], fits};
    endfunction

    always_comb begin
        {n_run_rem, n_run_q}   = div_step(r_run_rem, r_run_q, r_divisor);
        {n_rest_rem, n_rest_q} = div_step(r_rest_rem, r_rest_q, r_divisor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_done  <= 1'b0;
            r_count <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_count <= '0;
            end else if (r_busy) begin
                r_count <= r_count + 1'b1;
                if (r_count == CNT_W'(PHASE_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_run_rem  <= '0;
            r_rest_rem <= '0;
            r_run_q    <= i_run_dividend;
            r_rest_q   <= i_rest_dividend;
            r_divisor  <= (i_divisor == '0) ? SCALE_W'(1) : i_divisor;
        end else if (r_busy) begin
            r_run_rem  <= n_run_rem;
            r_rest_rem <= n_rest_rem;
            r_run_q    <= n_run_q;
            r_rest_q   <= n_rest_q;
        end
    end

    assign o_done   = r_done;
    assign o_run_q  = r_run_q;
    assign o_rest_q = r_rest_q;

endmodule

>>> src/pfrc_ctrl.sv
// ----------------------------------------------------------------------------
// pfrc_ctrl
// Sequencer: take a tick, drop it if ignored, else wait for the limits, then update and emit once the output is free.
// ----------------------------------------------------------------------------
module pfrc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  pfrc_pkg::t_status i_status,
    output pfrc_pkg::t_cmd    o_cmd
);
    import pfrc_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    logic [1:0] r_state, n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid && !i_status.ignore) begin
                    o_cmd.capture   = 1'b1;
                    o_cmd.div_start = 1'b1;
                    n_state         = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (i_status.div_done) begin
                    n_state = ST_EVAL;
                end
            end
            ST_EVAL: begin
                if (i_status.out_free) begin
                    o_cmd.eval = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> src/pfrc_dp.sv
// ----------------------------------------------------------------------------
// pfrc_dp
// Datapath: configuration, tick capture, cycle state and output frame.
// ----------------------------------------------------------------------------
module pfrc_dp (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pfrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  pfrc_pkg::t_tick                 i_tick,
    input  pfrc_pkg::t_cmd                  i_cmd,
    output pfrc_pkg::t_status               o_status,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [pfrc_pkg::CMD_W-1:0]      o_valve_command,
    output logic [pfrc_pkg::SEQ_W-1:0]      o_frame_count,
    output logic [pfrc_pkg::CHAN_W-1:0]     o_channel_out,
    output logic                            o_valve_second
);
    import pfrc_pkg::*;

    logic [MODE_W-1:0]         r_radio_mode;
    logic signed [DEPTH_W-1:0] r_target;
    logic [BAND_W-1:0]         r_deadband;
    logic [SCALE_W-1:0]        r_scale;
    logic [RESTSEL_W-1:0]      r_rest_sel;

    t_tick                     r_tick;
    logic                      r_fill, r_rest, n_fill, n_rest;
    logic [PHASE_W-1:0]        r_phase, n_phase;
    logic [SEQ_W-1:0]          r_seq;

    logic                      r_out_valid;
    logic [CMD_W-1:0]          r_out_cmd, n_cmd;
    logic [SEQ_W-1:0]          r_out_seq;
    logic [CHAN_W-1:0]         r_out_ch;
    logic                      r_out_vs, n_vs;

    logic                      div_done;
    logic [PHASE_W-1:0]        run_q, rest_q, rest_lim, rest_dividend;
    logic signed [DEPTH_W+1:0] threshold, avg_x;

    assign rest_dividend = PHASE_W'({9'd0, r_rest_sel} * {8'd0, REST_UNIT});

    pfrc_div u_div (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_cmd.div_start),
        .i_run_dividend  (RUN_SECONDS),
        .i_rest_dividend (rest_dividend),
        .i_divisor       (r_scale),
        .o_done          (div_done),
        .o_run_q         (run_q),
        .o_rest_q        (rest_q)
    );

    assign o_status.ignore   = (r_radio_mode == '0) || (i_tick.radio_channel == '0);
    assign o_status.div_done = div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radio_mode <= '0;
            r_target     <= '0;
            r_deadband   <= '0;
            r_scale      <= SCALE_W'(1);
            r_rest_sel   <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_RADIO_MODE:     r_radio_mode <= i_cfg_data[MODE_W-1:0];
                CFG_TARGET_DEPTH:   r_target     <= $signed(i_cfg_data[DEPTH_W-1:0]);
                CFG_FILL_DEADBAND:  r_deadband   <= i_cfg_data[BAND_W-1:0];
                CFG_TIME_SCALE:     r_scale      <= i_cfg_data[SCALE_W-1:0];
                CFG_REST_SELECTION: r_rest_sel   <= i_cfg_data[RESTSEL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_tick <= i_tick;
        end
    end

    assign threshold = {{2{r_target[DEPTH_W-1]}}, r_target} - $signed({3'b000, r_deadband});
    assign avg_x     = {{2{r_tick.average_depth[DEPTH_W-1]}}, r_tick.average_depth};
    assign rest_lim  = (rest_q == '0) ? PHASE_W'(1) : rest_q;

    always_comb begin
        n_fill  = r_fill;
        n_rest  = r_rest;
        n_phase = r_phase;
        n_vs    = 1'b0;
        if (!r_tick.sensor_ok) begin
            n_fill  = 1'b0;
            n_rest  = 1'b0;
            n_phase = '0;
        end
        if (r_tick.sensor_ok && r_tick.hours_allowed && !n_fill && (avg_x < threshold)) begin
            n_fill  = 1'b1;
            n_rest  = 1'b0;
            n_phase = '0;
        end
        if (!r_tick.hours_allowed && n_fill) begin
            n_fill  = 1'b0;
            n_rest  = 1'b0;
            n_phase = '0;
        end
        if (n_fill) begin
            n_phase = n_phase + 1'b1;
            if (!n_rest) begin
                n_vs = 1'b1;
                if (n_phase >= run_q) begin
                    n_rest  = 1'b1;
                    n_phase = '0;
                end
            end else if (n_phase >= rest_lim) begin
                n_fill  = 1'b0;
                n_rest  = 1'b0;
                n_phase = '0;
            end
        end
        n_cmd = !n_fill ? VALVE_CLOSED : (n_rest ? VALVE_REST : VALVE_FILL);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= 1'b0;
            r_rest      <= 1'b0;
            r_phase     <= '0;
            r_seq       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.eval) begin
                r_fill      <= n_fill;
                r_rest      <= n_rest;
                r_phase     <= n_phase;
                r_seq       <= r_seq + 1'b1;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.eval) begin
            r_out_cmd <= n_cmd;
            r_out_seq <= r_seq + 1'b1;
            r_out_ch  <= r_tick.radio_channel;
            r_out_vs  <= n_vs;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_valve_command = r_out_cmd;
    assign o_frame_count   = r_out_seq;
    assign o_channel_out   = r_out_ch;
    assign o_valve_second  = r_out_vs;

`ifndef NO_ASSERTIONS
    a_rest_in_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rest |-> r_fill)
        else $error("resting outside a fill cycle");

    a_seq_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |=> (r_seq == $past(r_seq) + 1'b1) && (r_out_seq == r_seq))
        else $error("frame count did not advance by one");

    a_second_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_vs) |-> (r_out_cmd != VALVE_CLOSED))
        else $error("valve second reported with valve closed");

    a_eval_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.eval |-> (!r_out_valid || i_out_ready))
        else $error("frame overwritten before transaction");
`endif

endmodule

>>> src/pump_fill_rest_cycle_controller.sv
// ----------------------------------------------------------------------------
// pump_fill_rest_cycle_controller
// Ignored ticks are dropped; any other tick is captured, the 17-step shared limit
// divider runs, the cycle state updates and the frame loads; then a new tick is
// taken. The output frame register lets the next tick in while a frame waits.
// Reset (synchronous, active low) clears cycle state, sequence count and config.
// ----------------------------------------------------------------------------
module pump_fill_rest_cycle_controller (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [pfrc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pfrc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pfrc_tick_if.sink                       i_tick,
    pfrc_frame_if.source                    o_frame
);
    import pfrc_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_tick   tick;

    assign tick.sensor_ok     = i_tick.sensor_ok;
    assign tick.hours_allowed = i_tick.hours_allowed;
    assign tick.average_depth = i_tick.average_depth;
    assign tick.radio_channel = i_tick.radio_channel;

    pfrc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_tick.valid),
        .o_ready  (i_tick.ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    pfrc_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_tick          (tick),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_out_ready     (o_frame.ready),
        .o_out_valid     (o_frame.valid),
        .o_valve_command (o_frame.valve_command),
        .o_frame_count   (o_frame.frame_count),
        .o_channel_out   (o_frame.channel_out),
        .o_valve_second  (o_frame.valve_second)
    );

endmodule
